// File: rtl/hpf_pkg.sv
// Shared types, constants and helper functions for the half-to-single pixel widener.
// Used by hpf_widen, hpf_recip, hpf_mul and the top level; depends on nothing.
package hpf_pkg;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_FIN  = 2'd1,
    CLS_INF  = 2'd2,
    CLS_NAN  = 2'd3
  } cls_e;

  // Widened number: sign, class, binary32 biased exponent, normalized 11-bit significand
  typedef struct packed {
    logic       sgn;
    cls_e       cls;
    logic [7:0] ex;
    logic [10:0] sig;
  } num_t;

  typedef struct packed {
    num_t r;
    num_t g;
    num_t b;
    num_t a;
    logic last;
  } pix_t;

  localparam int unsigned DivStages        = 4;
  localparam int unsigned DivStepsPerStage = 7;
  localparam int unsigned QuoW             = DivStages * DivStepsPerStage;

  typedef struct packed {
    logic [11:0]     rem;
    logic [QuoW-1:0] quo;
  } div_t;

  localparam logic [31:0] OneBits    = 32'h3F80_0000;
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [22:0] QuietMant  = 23'h40_0001;
  localparam logic [22:0] NanMant    = 23'h00_0001;
  localparam logic [7:0]  ExpMax     = 8'hFF;
  localparam logic [10:0] SigOne     = 11'd1024;

  function automatic num_t widen_half(logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] lz;
    logic       found;
    num_t       n;
    e     = h[14:10];
    m     = h[9:0];
    lz    = '0;
    found = 1'b0;
    n.sgn = h[15];
    n.cls = CLS_FIN;
    n.ex  = '0;
    n.sig = '0;
    if (e == 5'd0) begin
      if (m == 10'd0) begin
        n.cls = CLS_ZERO;
      end else begin
        for (int i = 9; i >= 0; i--) begin
          if (!found && m[i]) begin
            lz    = 4'(9 - i);
            found = 1'b1;
          end
        end
        n.sig = 11'({1'b0, m} << (lz + 4'd1));
        n.ex  = 8'd112 - {4'b0, lz};
      end
    end else if (e == 5'h1F) begin
      n.cls = (m != 10'd0) ? CLS_NAN : CLS_INF;
    end else begin
      n.ex  = {3'b0, e} + 8'd112;
      n.sig = {1'b1, m};
    end
    return n;
  endfunction

  function automatic logic [31:0] num_bits(num_t n);
    logic [31:0] res;
    unique case (n.cls)
      CLS_ZERO: res = {n.sgn, 31'b0};
      CLS_INF:  res = {n.sgn, ExpMax, 23'b0};
      CLS_NAN:  res = {n.sgn, ExpMax, NanMant};
      default:  res = {n.sgn, n.ex, n.sig[9:0], 13'b0};
    endcase
    return res;
  endfunction

  // A few restoring division steps: remainder doubles, quotient takes one bit per step
  function automatic div_t div_run(div_t x, logic [10:0] d);
    logic [11:0] r2;
    div_t        y;
    y  = x;
    r2 = '0;
    for (int i = 0; i < int'(DivStepsPerStage); i++) begin
      r2 = {y.rem[10:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        y.rem = r2 - {1'b0, d};
        y.quo = {y.quo[QuoW-2:0], 1'b1};
      end else begin
        y.rem = r2;
        y.quo = {y.quo[QuoW-2:0], 1'b0};
      end
    end
    return y;
  endfunction

endpackage

// File: rtl/half_pixel_to_float_unpremultiply.sv
// Top level of the half-to-single RGBA pixel widener with optional un-premultiply.
// Depends on hpf_pkg, hpf_widen, hpf_recip and hpf_mul.
//
//  channel  | direction | signals                                   | contents
//  ---------+-----------+-------------------------------------------+----------------------------
//  s_axis   | in        | s_axis_tvalid/tready/tdata[63:0]/tlast    | four binary16 pixel channels
//  m_axis   | out       | m_axis_tvalid/tready/tdata[127:0]/tlast   | four binary32 pixel channels
//  cfg      | in        | straighten_we_i, straighten_i             | un-premultiply enable
//
// One pixel beat per cycle is sustained while the sink keeps m_axis_tready high; each beat
// passes 8 register stages: widen (1), reciprocal divider stages (4, 7 quotient bits
// each), rounding of k (1), significand multiply (1), round and pack (1).
// Reset empties the pipeline and sets straighten to 1.
// The whole pipeline advances together: when the output beat is held by the sink,
// every stage holds, and s_axis_tready drops in the same cycle.
module half_pixel_to_float_unpremultiply (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         straighten_we_i,
  input  logic         straighten_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // fields from bit 0: red_half, green_half, blue_half, alpha_half
  input  logic [63:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fields from bit 0: red_single, green_single, blue_single, alpha_single
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tlast
);

  logic          straighten_q;
  logic          en;
  logic          vld_w, vld_r;
  hpf_pkg::pix_t pix_w, pix_r;
  logic [31:0]   k_r;

  // Advance whenever the output register is empty or being drained
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      straighten_q <= 1'b1;
    end else if (straighten_we_i) begin
      straighten_q <= straighten_i;
    end
  end

  hpf_widen u_widen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .data_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .vld_o  (vld_w),
    .pix_o  (pix_w)
  );

  hpf_recip u_recip (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .straighten_i (straighten_q),
    .vld_i        (vld_w),
    .pix_i        (pix_w),
    .vld_o        (vld_r),
    .pix_o        (pix_r),
    .k_o          (k_r)
  );

  hpf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_r),
    .pix_i  (pix_r),
    .k_i    (k_r),
    .vld_o  (m_axis_tvalid),
    .data_o (m_axis_tdata),
    .last_o (m_axis_tlast)
  );

  a_alpha_nan_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[126:119] == hpf_pkg::ExpMax &&
     m_axis_tdata[118:96] != 23'd0)
    |-> (m_axis_tdata[118:96] == hpf_pkg::NanMant))
    else $error("alpha NaN not in widened form");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_r && !en) |=> (vld_r && $stable(k_r)))
    else $error("reciprocal stage changed during a stall");

endmodule

// File: rtl/hpf_widen.sv
// Entry stage: widens the four binary16 channels into classified binary32 parts.
// Depends on hpf_pkg.
module hpf_widen (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [63:0]   data_i,
  input  logic          last_i,
  output logic          vld_o,
  output hpf_pkg::pix_t pix_o
);

  logic          vld_q;
  hpf_pkg::pix_t pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q.r    <= hpf_pkg::widen_half(data_i[15:0]);
      pix_q.g    <= hpf_pkg::widen_half(data_i[31:16]);
      pix_q.b    <= hpf_pkg::widen_half(data_i[47:32]);
      pix_q.a    <= hpf_pkg::widen_half(data_i[63:48]);
      pix_q.last <= last_i;
    end
  end

  assign vld_o = vld_q;
  assign pix_o = pix_q;

endmodule

// File: rtl/hpf_recip.sv
// Pipelined reciprocal of alpha: restoring divider stages, then a rounding stage for k.
// Depends on hpf_pkg.
module hpf_recip (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          straighten_i,
  input  logic          vld_i,
  input  hpf_pkg::pix_t pix_i,
  output logic          vld_o,
  output hpf_pkg::pix_t pix_o,
  output logic [31:0]   k_o
);

  localparam int unsigned NS = hpf_pkg::DivStages;
  localparam int unsigned QW = hpf_pkg::QuoW;

  logic [NS-1:0]  vld_q;
  hpf_pkg::pix_t  pix_q [NS];
  hpf_pkg::div_t  div_q [NS];
  hpf_pkg::div_t  div_init;

  logic           vld_k_q;
  hpf_pkg::pix_t  pix_k_q;
  logic [31:0]    k_q, k_d;

  assign div_init.rem = 12'({1'b0, hpf_pkg::SigOne});
  assign div_init.quo = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_k_q <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[NS-2:0], vld_i};
      vld_k_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q[0] <= pix_i;
      div_q[0] <= hpf_pkg::div_run(div_init, pix_i.a.sig);
      for (int s = 1; s < int'(NS); s++) begin
        pix_q[s] <= pix_q[s-1];
        div_q[s] <= hpf_pkg::div_run(div_q[s-1], pix_q[s-1].a.sig);
      end
      pix_k_q <= pix_q[NS-1];
      k_q     <= k_d;
    end
  end

  // Round the quotient to nearest even and assemble k
  hpf_pkg::num_t a_w;
  logic [QW-1:0] quo_w;
  logic          guard_w, sticky_w, up_w;
  logic [24:0]   mant_w;

  always_comb begin
    a_w      = pix_q[NS-1].a;
    quo_w    = div_q[NS-1].quo;
    guard_w  = quo_w[3];
    sticky_w = (|quo_w[2:0]) || (div_q[NS-1].rem != 12'd0);
    up_w     = guard_w && (sticky_w || quo_w[4]);
    mant_w   = {1'b0, quo_w[QW-1:4]} + {24'b0, up_w};
    k_d      = hpf_pkg::OneBits;
    if (straighten_i && (a_w.cls != hpf_pkg::CLS_ZERO)) begin
      priority if (a_w.cls == hpf_pkg::CLS_NAN) begin
        k_d = {a_w.sgn, hpf_pkg::ExpMax, hpf_pkg::QuietMant};
      end else if (a_w.cls == hpf_pkg::CLS_INF) begin
        k_d = {a_w.sgn, 31'b0};
      end else if (a_w.sig == hpf_pkg::SigOne || mant_w[24]) begin
        k_d = {a_w.sgn, 8'd254 - a_w.ex, 23'b0};
      end else begin
        k_d = {a_w.sgn, 8'd253 - a_w.ex, mant_w[22:0]};
      end
    end
  end

  assign vld_o = vld_k_q;
  assign pix_o = pix_k_q;
  assign k_o   = k_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NS-1] && pix_q[NS-1].a.cls == hpf_pkg::CLS_FIN &&
     pix_q[NS-1].a.sig != hpf_pkg::SigOne)
    |-> (div_q[NS-1].rem < {1'b0, pix_q[NS-1].a.sig}))
    else $error("divider remainder not below divisor");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_k_q && straighten_i && pix_k_q.a.cls == hpf_pkg::CLS_FIN)
    |-> (k_q[30:23] != 8'd0 && k_q[30:23] != hpf_pkg::ExpMax))
    else $error("reciprocal exponent out of normal range");

endmodule

// File: rtl/hpf_mul.sv
// Scaling stages: multiplies the colour significands by k, then rounds into the output register.
// Depends on hpf_pkg.
module hpf_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  hpf_pkg::pix_t pix_i,
  input  logic [31:0]   k_i,
  output logic          vld_o,
  output logic [127:0]  data_o,
  output logic          last_o
);

  logic          vld_p_q;
  hpf_pkg::pix_t pix_p_q;
  logic [31:0]   k_p_q;
  logic [34:0]   prod_r_q, prod_g_q, prod_b_q;

  logic          vld_o_q;
  logic [127:0]  data_q, data_d;
  logic          last_q;

  function automatic logic [31:0] finish(hpf_pkg::num_t c, logic [34:0] p, logic [31:0] k);
    logic        k_nan, k_zero, sg, g, st, up;
    logic [23:0] sig;
    logic [24:0] m;
    logic [9:0]  e;
    logic [31:0] res;
    k_nan  = (k[30:23] == hpf_pkg::ExpMax) && (k[22:0] != 23'd0);
    k_zero = (k[30:0] == 31'd0);
    sg     = c.sgn ^ k[31];
    e      = {2'b0, c.ex} + {2'b0, k[30:23]} - 10'd127;
    if (p[34]) begin
      sig = p[34:11];
      g   = p[10];
      st  = |p[9:0];
      e   = e + 10'd1;
    end else begin
      sig = p[33:10];
      g   = p[9];
      st  = |p[8:0];
    end
    up = g && (st || sig[0]);
    m  = {1'b0, sig} + {24'b0, up};
    if (m[24]) begin
      e   = e + 10'd1;
      res = {sg, e[7:0], 23'b0};
    end else begin
      res = {sg, e[7:0], m[22:0]};
    end
    priority if (c.cls == hpf_pkg::CLS_NAN) begin
      res = {c.sgn, hpf_pkg::ExpMax, hpf_pkg::QuietMant};
    end else if (k_nan) begin
      res = k;
    end else if (c.cls == hpf_pkg::CLS_INF) begin
      res = k_zero ? hpf_pkg::DefaultNan : {sg, hpf_pkg::ExpMax, 23'b0};
    end else if (c.cls == hpf_pkg::CLS_ZERO || k_zero) begin
      res = {sg, 31'b0};
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q <= 1'b0;
      vld_o_q <= 1'b0;
    end else if (en_i) begin
      vld_p_q <= vld_i;
      vld_o_q <= vld_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_p_q  <= pix_i;
      k_p_q    <= k_i;
      prod_r_q <= pix_i.r.sig * {1'b1, k_i[22:0]};
      prod_g_q <= pix_i.g.sig * {1'b1, k_i[22:0]};
      prod_b_q <= pix_i.b.sig * {1'b1, k_i[22:0]};
      data_q   <= data_d;
      last_q   <= pix_p_q.last;
    end
  end

  always_comb begin
    data_d[31:0]   = finish(pix_p_q.r, prod_r_q, k_p_q);
    data_d[63:32]  = finish(pix_p_q.g, prod_g_q, k_p_q);
    data_d[95:64]  = finish(pix_p_q.b, prod_b_q, k_p_q);
    data_d[127:96] = hpf_pkg::num_bits(pix_p_q.a);
  end

  assign vld_o  = vld_o_q;
  assign data_o = data_q;
  assign last_o = last_q;

  a_red_nan_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_o_q && data_q[30:23] == hpf_pkg::ExpMax && data_q[22:0] != 23'd0)
    |-> data_q[22])
    else $error("red result is a signaling NaN");

endmodule
